>>> hdl/colstat_pkg.sv
// shared constants, types and codes of the column row statistics block
package colstat_pkg;

   localparam int COLUMNS    = 16;
   localparam int COL_BITS   = $clog2(COLUMNS);
   localparam int NCOL_BITS  = COL_BITS + 1;
   localparam int COUNT_BITS = 17;
   localparam int VALUE_BITS = 64;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(1) << (COUNT_BITS - 1);

   localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

   typedef enum logic [2:0] {
      OP_BEGIN     = 3'd0,
      OP_SET_VALUE = 3'd1,
      OP_SET_NULL  = 3'd2,
      OP_FINISH    = 3'd3,
      OP_READ      = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_ROW_STATE = 3'd1,
      STAT_COL_RANGE = 3'd2,
      STAT_TIME_BACK = 3'd3,
      STAT_COL_SET   = 3'd4
   } status_type;

   typedef enum logic {
      CSR_NUM_COLUMNS = 1'b0,
      CSR_MAX_ROWS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] min_val;
      logic signed [VALUE_BITS-1:0] max_val;
      logic signed [VALUE_BITS-1:0] last_val;
      logic                         seen;
      logic                         constant;
      logic [COUNT_BITS-1:0]        runs;
      logic [COUNT_BITS-1:0]        nulls;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      min_val:  '0,
      max_val:  '0,
      last_val: '0,
      seen:     1'b0,
      constant: 1'b1,
      runs:     '0,
      nulls:    '0
   };

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
      return (c < COUNT_MAX) ? c + COUNT_BITS'(1) : COUNT_MAX;
   endfunction

endpackage

>>> hdl/column_row_statistics_top.sv
// per-column running statistics over a row stream, column entries held in a memory
//
// req channel: one transaction per operation (begin row, set value, set null,
// finish row, read column). rsp channel: exactly one transaction per request,
// carrying status, the addressed column's statistics after the operation and
// the row-level totals. csr channel: index 0 num_columns, 1 row capacity, always ready.
// A request is taken only while the engine is idle. A begin, a read or a rejected
// operation passes through the execute and final states; an accepted set adds a
// modify state, an accepted finish a sweep read and a sweep write state per active
// column. The engine returns to idle when the final state loads the output register.
// The column memory has a single read and a single write port with a registered read;
// set does one read-modify-write, finish walks the active columns with one read each
// and a write to each column not set in the row. The result sits in an output register,
// so a new request is accepted while the previous response waits; the engine stalls
// only when its next result is ready and the output register is still full.
// Reset is synchronous: per-entry valid bits make every column read as cleared
// on the next cycle, no clearing pass is needed.
module column_row_statistics_top
   import colstat_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_op,
   input  logic [3:0]                   req_column,
   input  logic signed [63:0]           req_value,
   input  logic signed [63:0]           req_timestamp,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic signed [63:0]           rsp_col_min,
   output logic signed [63:0]           rsp_col_max,
   output logic                         rsp_col_has_value,
   output logic [16:0]                  rsp_run_total,
   output logic [16:0]                  rsp_null_total,
   output logic                         rsp_is_constant,
   output logic [16:0]                  rsp_rows_done,
   output logic signed [63:0]           rsp_time_low,
   output logic signed [63:0]           rsp_time_high,
   output logic                         rsp_chunk_full,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [16:0]                  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MODIFY,
      ST_SWEEP_RD,
      ST_SWEEP_WR,
      ST_FINAL
   } state_type;

   state_type state_ff;

   logic [4:0]                    num_columns_ff;
   logic [16:0]                   row_cap_ff;

   logic [2:0]                    op_ff;
   logic [COL_BITS-1:0]           col_ff;
   logic signed [VALUE_BITS-1:0]  value_ff;
   logic signed [VALUE_BITS-1:0]  timestamp_ff;
   status_type                    status_ff;
   logic [COL_BITS-1:0]           idx_ff;

   logic [COLUMNS-1:0]            set_in_row_ff;
   logic                          row_open_ff;
   logic signed [VALUE_BITS-1:0]  current_time_ff;
   logic signed [VALUE_BITS-1:0]  latest_time_ff;
   logic signed [VALUE_BITS-1:0]  time_min_ff;
   logic signed [VALUE_BITS-1:0]  time_max_ff;
   logic [COUNT_BITS-1:0]         row_total_ff;

   entry_type                     mem [COLUMNS];
   logic [COLUMNS-1:0]            entry_valid_ff;
   entry_type                     rd_data_ff;
   logic                          rd_valid_ff;

   logic                          rsp_valid_ff;
   logic [2:0]                    rsp_status_ff;
   logic signed [VALUE_BITS-1:0]  rsp_col_min_ff;
   logic signed [VALUE_BITS-1:0]  rsp_col_max_ff;
   logic                          rsp_col_has_value_ff;
   logic [COUNT_BITS-1:0]         rsp_run_total_ff;
   logic [COUNT_BITS-1:0]         rsp_null_total_ff;
   logic                          rsp_is_constant_ff;
   logic [COUNT_BITS-1:0]         rsp_rows_done_ff;
   logic signed [VALUE_BITS-1:0]  rsp_time_low_ff;
   logic signed [VALUE_BITS-1:0]  rsp_time_high_ff;
   logic                          rsp_chunk_full_ff;

   logic [NCOL_BITS-1:0]          ncols;
   logic                          in_range;
   entry_type                     cur_entry;
   entry_type                     value_entry_in;
   entry_type                     null_entry_in;
   logic                          mem_wr_en;
   logic [COL_BITS-1:0]           mem_wr_addr;
   entry_type                     mem_wr_data;
   logic [COL_BITS-1:0]           mem_rd_addr;
   logic                          same_entry;
   logic                          sweep_last;
   logic                          out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (num_columns_ff == 5'd0) begin
         ncols = NCOL_BITS'(1);
      end else if (num_columns_ff > 5'(COLUMNS)) begin
         ncols = NCOL_BITS'(COLUMNS);
      end else begin
         ncols = NCOL_BITS'(num_columns_ff);
      end
   end

   assign in_range   = {1'b0, col_ff} < ncols;
   assign sweep_last = ({1'b0, idx_ff} == ncols - NCOL_BITS'(1));
   assign cur_entry  = rd_valid_ff ? rd_data_ff : ENTRY_RESET;

   always_comb begin
      value_entry_in = cur_entry;
      if (!cur_entry.seen) begin
         value_entry_in.min_val = value_ff;
         value_entry_in.max_val = value_ff;
         value_entry_in.runs    = COUNT_BITS'(1);
         value_entry_in.seen    = 1'b1;
      end else begin
         if (value_ff < cur_entry.min_val) begin
            value_entry_in.min_val = value_ff;
         end
         if (cur_entry.max_val < value_ff) begin
            value_entry_in.max_val = value_ff;
         end
         if (value_ff != cur_entry.last_val) begin
            value_entry_in.constant = 1'b0;
            value_entry_in.runs     = sat_inc(cur_entry.runs);
         end
      end
      value_entry_in.last_val = value_ff;

      null_entry_in       = cur_entry;
      null_entry_in.nulls = sat_inc(cur_entry.nulls);
   end

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = col_ff;
      mem_wr_data = null_entry_in;
      mem_rd_addr = col_ff;
      case (state_ff)
         ST_MODIFY: begin
            mem_wr_en = 1'b1;
            if (op_ff == OP_SET_VALUE) begin
               mem_wr_data = value_entry_in;
            end
         end
         ST_SWEEP_RD: begin
            mem_rd_addr = idx_ff;
         end
         ST_SWEEP_WR: begin
            mem_wr_en   = !set_in_row_ff[idx_ff];
            mem_wr_addr = idx_ff;
         end
         default: begin
         end
      endcase
   end

   assign same_entry = mem_wr_en && (mem_wr_addr == mem_rd_addr);

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (same_entry) begin
         rd_data_ff <= mem_wr_data;
      end else begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (mem_wr_en) begin
            entry_valid_ff[mem_wr_addr] <= 1'b1;
         end
         rd_valid_ff <= same_entry || entry_valid_ff[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_columns_ff <= 5'(COLUMNS);
         row_cap_ff     <= 17'(COUNT_MAX);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_COLUMNS: num_columns_ff <= csr_data[4:0];
            CSR_MAX_ROWS:    row_cap_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         set_in_row_ff   <= '0;
         row_open_ff     <= 1'b0;
         current_time_ff <= '0;
         latest_time_ff  <= MOST_NEG;
         time_min_ff     <= MOST_POS;
         time_max_ff     <= MOST_NEG;
         row_total_ff    <= '0;
         status_ff       <= STAT_OK;
         idx_ff          <= '0;
      end else begin
         if (state_ff == ST_FINAL && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff        <= req_op;
                  col_ff       <= req_column;
                  value_ff     <= req_value;
                  timestamp_ff <= req_timestamp;
                  state_ff     <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               case (op_ff)
                  OP_BEGIN: begin
                     state_ff <= ST_FINAL;
                     if (row_open_ff) begin
                        status_ff <= STAT_ROW_STATE;
                     end else if (timestamp_ff < latest_time_ff) begin
                        status_ff <= STAT_TIME_BACK;
                     end else begin
                        status_ff       <= STAT_OK;
                        row_open_ff     <= 1'b1;
                        current_time_ff <= timestamp_ff;
                        latest_time_ff  <= timestamp_ff;
                        set_in_row_ff   <= '0;
                     end
                  end
                  OP_SET_VALUE, OP_SET_NULL: begin
                     if (!row_open_ff) begin
                        status_ff <= STAT_ROW_STATE;
                        state_ff  <= ST_FINAL;
                     end else if (!in_range) begin
                        status_ff <= STAT_COL_RANGE;
                        state_ff  <= ST_FINAL;
                     end else if (set_in_row_ff[col_ff]) begin
                        status_ff <= STAT_COL_SET;
                        state_ff  <= ST_FINAL;
                     end else begin
                        status_ff             <= STAT_OK;
                        set_in_row_ff[col_ff] <= 1'b1;
                        state_ff              <= ST_MODIFY;
                     end
                  end
                  OP_FINISH: begin
                     if (!row_open_ff) begin
                        status_ff <= STAT_ROW_STATE;
                        state_ff  <= ST_FINAL;
                     end else begin
                        status_ff <= STAT_OK;
                        if (current_time_ff < time_min_ff) begin
                           time_min_ff <= current_time_ff;
                        end
                        if (time_max_ff < current_time_ff) begin
                           time_max_ff <= current_time_ff;
                        end
                        row_total_ff <= sat_inc(row_total_ff);
                        idx_ff       <= '0;
                        state_ff     <= ST_SWEEP_RD;
                     end
                  end
                  OP_READ: begin
                     status_ff <= in_range ? STAT_OK : STAT_COL_RANGE;
                     state_ff  <= ST_FINAL;
                  end
                  default: begin
                     status_ff <= STAT_ROW_STATE;
                     state_ff  <= ST_FINAL;
                  end
               endcase
            end
            ST_MODIFY: begin
               state_ff <= ST_FINAL;
            end
            ST_SWEEP_RD: begin
               state_ff <= ST_SWEEP_WR;
            end
            ST_SWEEP_WR: begin
               if (sweep_last) begin
                  row_open_ff   <= 1'b0;
                  set_in_row_ff <= '0;
                  state_ff      <= ST_FINAL;
               end else begin
                  idx_ff   <= idx_ff + COL_BITS'(1);
                  state_ff <= ST_SWEEP_RD;
               end
            end
            ST_FINAL: begin
               if (out_free) begin
                  rsp_status_ff        <= status_ff;
                  rsp_col_has_value_ff <= in_range && cur_entry.seen;
                  rsp_col_min_ff       <= (in_range && cur_entry.seen) ? cur_entry.min_val : '0;
                  rsp_col_max_ff       <= (in_range && cur_entry.seen) ? cur_entry.max_val : '0;
                  rsp_run_total_ff     <= in_range ? cur_entry.runs : '0;
                  rsp_null_total_ff    <= in_range ? cur_entry.nulls : '0;
                  rsp_is_constant_ff   <= in_range && cur_entry.constant;
                  rsp_rows_done_ff     <= row_total_ff;
                  rsp_time_low_ff      <= time_min_ff;
                  rsp_time_high_ff     <= time_max_ff;
                  rsp_chunk_full_ff    <= (row_total_ff >= row_cap_ff);
                  state_ff             <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_col_min       = rsp_col_min_ff;
   assign rsp_col_max       = rsp_col_max_ff;
   assign rsp_col_has_value = rsp_col_has_value_ff;
   assign rsp_run_total     = rsp_run_total_ff;
   assign rsp_null_total    = rsp_null_total_ff;
   assign rsp_is_constant   = rsp_is_constant_ff;
   assign rsp_rows_done     = rsp_rows_done_ff;
   assign rsp_time_low      = rsp_time_low_ff;
   assign rsp_time_high     = rsp_time_high_ff;
   assign rsp_chunk_full    = rsp_chunk_full_ff;

endmodule
